// ===== hdl/pvs_pkg.sv =====
// Shared constants and types for the pointer viewport scaler.
package pvs_pkg;

    localparam int POS_W      = 16;
    localparam int SIZE_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUOT_W     = 16;
    localparam int NUM_W      = SIZE_W + QUOT_W;
    // Offset and range check, numerator, then one quotient bit per stage.
    localparam int LANE_STAGES = QUOT_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LEFT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TOP      = 3'd5;

    localparam logic [POS_W-1:0] FULL_SCALE    = 16'h7FFF;
    localparam logic [POS_W-1:0] OUT_OF_BOUNDS = 16'h8000;

    typedef logic [LANE_STAGES-1:0] t_stage_en;

endpackage

// ===== hdl/pvs_lane.sv =====
// One axis mapper: offset, range check and a pipelined restoring divider.
module pvs_lane (
    input  logic                                i_clk,
    input  pvs_pkg::t_stage_en                  i_adv,
    input  logic signed [pvs_pkg::POS_W-1:0]    i_pos,
    input  logic signed [pvs_pkg::POS_W-1:0]    i_offset,
    input  logic        [pvs_pkg::SIZE_W-1:0]   i_size,
    input  logic                                i_ok,
    output logic        [pvs_pkg::POS_W-1:0]    o_value
);
    import pvs_pkg::*;

    logic signed [POS_W:0]  s_rel;
    logic                   s_inr;
    logic [NUM_W-1:0]       s_num;

    logic [SIZE_W-1:0]      r_pos;
    logic                   r_inr [0:LANE_STAGES-1];
    logic [SIZE_W-1:0]      r_rem [0:QUOT_W];
    logic [QUOT_W-1:0]      r_wrk [0:QUOT_W];

    assign s_rel = $signed({i_pos[POS_W-1], i_pos}) - $signed({i_offset[POS_W-1], i_offset});
    assign s_inr = i_ok && !s_rel[POS_W] && (s_rel[POS_W-1:0] <= {1'b0, i_size});

    // pos * 65534 written as pos * 65536 - pos * 2.
    assign s_num = {r_pos, {QUOT_W{1'b0}}} - {{(NUM_W-SIZE_W-1){1'b0}}, r_pos, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_pos    <= s_rel[SIZE_W-1:0];
            r_inr[0] <= s_inr;
        end
        if (i_adv[1]) begin
            r_rem[0] <= s_num[NUM_W-1:QUOT_W];
            r_wrk[0] <= s_num[QUOT_W-1:0];
            r_inr[1] <= r_inr[0];
        end
    end

    for (genvar g = 0; g < QUOT_W; g++) begin : g_div
        logic [SIZE_W:0]   s_trial;
        logic              s_ge;
        logic [SIZE_W-1:0] s_diff;

        assign s_trial = {r_rem[g], r_wrk[g][QUOT_W-1]};
        assign s_ge    = s_trial >= {1'b0, i_size};
        assign s_diff  = s_trial[SIZE_W-1:0] - i_size;

        always_ff @(posedge i_clk) begin
            if (i_adv[g+2]) begin
                r_rem[g+1] <= s_ge ? s_diff : s_trial[SIZE_W-1:0];
                r_wrk[g+1] <= {r_wrk[g][QUOT_W-2:0], s_ge};
                r_inr[g+2] <= r_inr[g+1];
            end
        end
    end

    assign o_value = r_inr[LANE_STAGES-1] ? (r_wrk[QUOT_W] - FULL_SCALE) : OUT_OF_BOUNDS;

endmodule

// ===== hdl/pointer_viewport_scaler_core.sv =====
// Top level of the pointer viewport scaler: configuration, four axis lanes and output stage.
//
//  channel  | handshake                 | beat contents
//  ---------+---------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_ready   | i_pointer_x, i_pointer_y
//  output   | o_out_valid / i_out_ready | o_ok, o_view_x/y_scaled, o_screen_x/y_scaled
//  config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One beat enters per cycle unless a stalled output backs up to the input; each result
// passes the offset, numerator, 16 one-bit divide and output stages in order.
// Reset is synchronous and active low; it clears the configuration and all valid bits.
// A stalled output holds only the stages that are full behind it; empty stages
// keep taking beats, so bubbles close up.
module pointer_viewport_scaler_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic        [pvs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic        [pvs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [pvs_pkg::POS_W-1:0]       i_pointer_x,
    input  logic signed [pvs_pkg::POS_W-1:0]       i_pointer_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_ok,
    output logic signed [pvs_pkg::POS_W-1:0]       o_view_x_scaled,
    output logic signed [pvs_pkg::POS_W-1:0]       o_view_y_scaled,
    output logic signed [pvs_pkg::POS_W-1:0]       o_screen_x_scaled,
    output logic signed [pvs_pkg::POS_W-1:0]       o_screen_y_scaled
);
    import pvs_pkg::*;

    logic [SIZE_W-1:0]       r_view_width;
    logic [SIZE_W-1:0]       r_view_height;
    logic [SIZE_W-1:0]       r_screen_width;
    logic [SIZE_W-1:0]       r_screen_height;
    logic signed [POS_W-1:0] r_view_left;
    logic signed [POS_W-1:0] r_view_top;

    logic                    r_vld [0:LANE_STAGES-1];
    logic                    r_okp [0:LANE_STAGES-1];
    logic                    r_out_valid;
    logic                    r_ok;
    logic [POS_W-1:0]        r_vx;
    logic [POS_W-1:0]        r_vy;
    logic [POS_W-1:0]        r_sx;
    logic [POS_W-1:0]        r_sy;

    logic [LANE_STAGES:0]    s_rdy;
    t_stage_en               s_adv;
    logic                    s_ok;
    logic [POS_W-1:0]        s_vx;
    logic [POS_W-1:0]        s_vy;
    logic [POS_W-1:0]        s_sx;
    logic [POS_W-1:0]        s_sy;
    logic                    n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_width    <= '0;
            r_view_height   <= '0;
            r_screen_width  <= '0;
            r_screen_height <= '0;
            r_view_left     <= '0;
            r_view_top      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VIEW_WIDTH:    r_view_width    <= i_cfg_data[SIZE_W-1:0];
                CFG_VIEW_HEIGHT:   r_view_height   <= i_cfg_data[SIZE_W-1:0];
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[SIZE_W-1:0];
                CFG_VIEW_LEFT:     r_view_left     <= i_cfg_data;
                CFG_VIEW_TOP:      r_view_top      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ok = (r_view_width != '0) && (r_view_height != '0) &&
                  (r_screen_width != '0) && (r_screen_height != '0);

    always_comb begin
        s_rdy[LANE_STAGES] = !r_out_valid || i_out_ready;
        for (int k = LANE_STAGES - 1; k >= 0; k--) begin
            s_rdy[k] = !r_vld[k] || s_rdy[k+1];
        end
    end

    assign s_adv      = s_rdy[LANE_STAGES-1:0];
    assign o_in_ready = s_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (s_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < LANE_STAGES; k++) begin
                if (s_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv[0]) begin
            r_okp[0] <= s_ok;
        end
        for (int k = 1; k < LANE_STAGES; k++) begin
            if (s_adv[k]) begin
                r_okp[k] <= r_okp[k-1];
            end
        end
    end

    pvs_lane u_lane_vx (
        .i_clk    (i_clk),
        .i_adv    (s_adv),
        .i_pos    (i_pointer_x),
        .i_offset (r_view_left),
        .i_size   (r_view_width),
        .i_ok     (s_ok),
        .o_value  (s_vx)
    );

    pvs_lane u_lane_vy (
        .i_clk    (i_clk),
        .i_adv    (s_adv),
        .i_pos    (i_pointer_y),
        .i_offset (r_view_top),
        .i_size   (r_view_height),
        .i_ok     (s_ok),
        .o_value  (s_vy)
    );

    pvs_lane u_lane_sx (
        .i_clk    (i_clk),
        .i_adv    (s_adv),
        .i_pos    (i_pointer_x),
        .i_offset ('0),
        .i_size   (r_screen_width),
        .i_ok     (s_ok),
        .o_value  (s_sx)
    );

    pvs_lane u_lane_sy (
        .i_clk    (i_clk),
        .i_adv    (s_adv),
        .i_pos    (i_pointer_y),
        .i_offset ('0),
        .i_size   (r_screen_height),
        .i_ok     (s_ok),
        .o_value  (s_sy)
    );

    assign n_out_valid = s_rdy[LANE_STAGES] ? r_vld[LANE_STAGES-1] : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[LANE_STAGES]) begin
            r_ok <= r_okp[LANE_STAGES-1];
            r_vx <= s_vx;
            r_vy <= s_vy;
            r_sx <= s_sx;
            r_sy <= s_sy;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_ok              = r_ok;
    assign o_view_x_scaled   = r_vx;
    assign o_view_y_scaled   = r_vy;
    assign o_screen_x_scaled = r_sx;
    assign o_screen_y_scaled = r_sy;

endmodule

// ===== hdl/pvs_checker.sv =====
// Port-level checks for the pointer viewport scaler and the bind that attaches them.
module pvs_port_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   o_in_ready,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic                                   o_ok,
    input logic signed [pvs_pkg::POS_W-1:0]       o_view_x_scaled,
    input logic signed [pvs_pkg::POS_W-1:0]       o_view_y_scaled,
    input logic signed [pvs_pkg::POS_W-1:0]       o_screen_x_scaled,
    input logic signed [pvs_pkg::POS_W-1:0]       o_screen_y_scaled
);
    import pvs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Output beat dropped before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable({o_ok, o_view_x_scaled, o_view_y_scaled,
                     o_screen_x_scaled, o_screen_y_scaled}))
        else $error("Output beat changed while it was waiting.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input stalled while the output stage is empty.");

    a_not_ok_oob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |->
            o_view_x_scaled == OUT_OF_BOUNDS && o_view_y_scaled == OUT_OF_BOUNDS &&
            o_screen_x_scaled == OUT_OF_BOUNDS && o_screen_y_scaled == OUT_OF_BOUNDS)
        else $error("Scaled value present while a size is zero.");

endmodule

bind pointer_viewport_scaler_core pvs_port_checker u_pvs_checker (.*);
